[design/gfau_pkg.sv]
// Package for the GF(2^8) arithmetic unit: operation codes, stage payload
// types, the carryless multiply function and the inverse table.
// No dependencies.
`default_nettype none

package gfau_pkg;

   typedef logic [2:0] kind_type;
   typedef logic [7:0] elem_type;
   typedef elem_type byte_table_type [256];

   localparam kind_type KIND_ADD = 3'd0;
   localparam kind_type KIND_SUB = 3'd1;
   localparam kind_type KIND_MUL = 3'd2;
   localparam kind_type KIND_DIV = 3'd3;
   localparam kind_type KIND_INV = 3'd4;

   localparam elem_type POLY_LOW = 8'h1B;
   localparam elem_type GENERATOR = 8'h03;

   typedef struct packed {
      kind_type kind;
      elem_type operand_a;
      elem_type operand_b;
   } req_type;

   typedef struct packed {
      kind_type kind;
      elem_type operand_a;
      elem_type operand_b;
      elem_type inverse;
   } s1_type;

   typedef struct packed {
      kind_type kind;
      elem_type sum;
      elem_type product;
      elem_type inverse;
      logic     b_zero;
   } s2_type;

   typedef struct packed {
      elem_type field_result;
      logic     zero_divisor;
   } rsp_type;

   function automatic elem_type gf_mul(input elem_type a, input elem_type b);
      elem_type acc;
      elem_type cur;
      acc = '0;
      cur = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ cur;
         end
         cur = cur[7] ? ((cur << 1) ^ POLY_LOW) : (cur << 1);
      end
      return acc;
   endfunction

   // inverse via exp/log of generator 3; zero maps to zero
   function automatic byte_table_type build_inv_table();
      byte_table_type exp_t;
      byte_table_type log_t;
      byte_table_type inv_t;
      elem_type       p;
      p = 8'h01;
      for (int i = 0; i < 256; i++) begin
         exp_t[i] = '0;
         log_t[i] = '0;
         inv_t[i] = '0;
      end
      for (int i = 0; i < 255; i++) begin
         exp_t[i] = p;
         log_t[p] = 8'(i);
         p = gf_mul(p, GENERATOR);
      end
      for (int i = 1; i < 256; i++) begin
         inv_t[i] = exp_t[8'((255 - int'(log_t[i])) % 255)];
      end
      return inv_t;
   endfunction

   localparam byte_table_type INV_TABLE = build_inv_table();

endpackage

`default_nettype wire

[design/gfau_req_if.sv]
// Request channel interface of the GF(2^8) arithmetic unit.
// Depends on gfau_pkg.
`default_nettype none

interface gfau_req_if;
   logic               valid;
   logic               ready;
   gfau_pkg::kind_type kind;
   gfau_pkg::elem_type operand_a;
   gfau_pkg::elem_type operand_b;

   modport source (output valid, output kind, output operand_a, output operand_b,
                   input ready);
   modport sink (input valid, input kind, input operand_a, input operand_b,
                 output ready);
endinterface

`default_nettype wire

[design/gfau_rsp_if.sv]
// Response channel interface of the GF(2^8) arithmetic unit.
// Depends on gfau_pkg.
`default_nettype none

interface gfau_rsp_if;
   logic               valid;
   logic               ready;
   gfau_pkg::elem_type field_result;
   logic               zero_divisor;

   modport source (output valid, output field_result, output zero_divisor,
                   input ready);
   modport sink (input valid, input field_result, input zero_divisor,
                 output ready);
endinterface

`default_nettype wire

[design/gfau_inv_stage.sv]
// Stage 1: registers the request and looks up the inverse of operand_b.
// Depends on gfau_pkg.
`default_nettype none

module gfau_inv_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire gfau_pkg::req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output gfau_pkg::s1_type      out_data
);
   import gfau_pkg::*;

   logic   valid_ff, valid_in;
   s1_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in          = in_valid;
         data_in.kind      = in_data.kind;
         data_in.operand_a = in_data.operand_a;
         data_in.operand_b = in_data.operand_b;
         data_in.inverse   = INV_TABLE[in_data.operand_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[design/gfau_mul_stage.sv]
// Stage 2: carryless multiply with reduction, XOR sum and zero check.
// Depends on gfau_pkg.
`default_nettype none

module gfau_mul_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire gfau_pkg::s1_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output gfau_pkg::s2_type      out_data
);
   import gfau_pkg::*;

   logic     valid_ff, valid_in;
   s2_type   data_ff, data_in;
   elem_type mul_b;

   assign in_ready = !valid_ff || out_ready;
   assign mul_b    = (in_data.kind == KIND_MUL) ? in_data.operand_b : in_data.inverse;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in        = in_valid;
         data_in.kind    = in_data.kind;
         data_in.sum     = in_data.operand_a ^ in_data.operand_b;
         data_in.product = gf_mul(in_data.operand_a, mul_b);
         data_in.inverse = in_data.inverse;
         data_in.b_zero  = (in_data.operand_b == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[design/gfau_out_stage.sv]
// Stage 3: selects the result by operation and holds the response register.
// Depends on gfau_pkg.
`default_nettype none

module gfau_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire gfau_pkg::s2_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output gfau_pkg::rsp_type     out_data
);
   import gfau_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   rsp_type sel;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      sel = '0;
      case (in_data.kind) inside
         KIND_ADD, KIND_SUB: sel.field_result = in_data.sum;
         KIND_MUL:           sel.field_result = in_data.product;
         KIND_DIV: begin
            sel.field_result = in_data.b_zero ? '0 : in_data.product;
            sel.zero_divisor = in_data.b_zero;
         end
         KIND_INV: begin
            sel.field_result = in_data.b_zero ? '0 : in_data.inverse;
            sel.zero_divisor = in_data.b_zero;
         end
         default: sel = '0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         data_in  = sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[design/gf256_arithmetic_unit.sv]
// GF(2^8) arithmetic unit, AES polynomial x^8+x^4+x^3+x+1.
// Request channel req (valid/ready): kind, operand_a, operand_b.
//   kind: add, subtract (XOR), multiply, divide (a * inverse of b),
//   inverse of operand_b. Unused codes return 0.
// Response channel rsp (valid/ready): field_result, zero_divisor.
//   zero_divisor is set, and field_result is 0, for divide or inverse
//   with operand_b equal to zero.
// A transfer happens on a rising clock edge with valid and ready high.
// Three register stages: inverse table lookup, carryless multiply with
// reduction, result select into the response register.
// The response passes the inverse, multiply and output registers after the
// request transfer; one item per cycle sustained while rsp.ready is high.
// Each stage is ready when empty or when the next stage takes its item,
// so a stalled receiver fills the pipe, then req.ready drops; nothing is
// lost or repeated.
// Reset (synchronous, active high) empties all stages.
// Depends on gfau_pkg, gfau_req_if, gfau_rsp_if and the stage modules.
`default_nettype none

module gf256_arithmetic_unit (
   input wire logic clock,
   input wire logic reset,
   gfau_req_if.sink   req,
   gfau_rsp_if.source rsp
);
   import gfau_pkg::*;

   req_type req_data;
   s1_type  s1_data;
   s2_type  s2_data;
   rsp_type rsp_data;
   logic    s1_valid, s1_ready;
   logic    s2_valid, s2_ready;

   assign req_data.kind      = req.kind;
   assign req_data.operand_a = req.operand_a;
   assign req_data.operand_b = req.operand_b;

   gfau_inv_stage u_inv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   gfau_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   gfau_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp_data)
   );

   assign rsp.field_result = rsp_data.field_result;
   assign rsp.zero_divisor = rsp_data.zero_divisor;

   // items in flight, for checks only
   logic [2:0] occ_ff, occ_in;

   always_comb begin
      occ_in = occ_ff;
      case ({req.valid && req.ready, rsp.valid && rsp.ready})
         2'b10:   occ_in = occ_ff + 3'd1;
         2'b01:   occ_in = occ_ff - 3'd1;
         default: occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_occ_max: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= 3'd3)
      else $error("more than three items in flight");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> occ_ff != 3'd0)
      else $error("response valid with empty pipeline");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp.valid && !rsp.ready))
      else $error("request stalled while response side is free");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == 3'd3 && !rsp.ready) |-> !req.ready)
      else $error("full pipeline took a transfer under stall");

endmodule

`default_nettype wire
